>>> rtl/dsa_pkg.sv
// Shared types, codes and constants of the descriptor slot allocator.
package dsa_pkg;

  localparam int unsigned SlotCountDefault = 1024;
  localparam int unsigned AddrW = 64;
  localparam int unsigned StrideW = 12;
  localparam int unsigned IndexW = 16;
  localparam int unsigned UsedW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [StrideW-1:0] StrideReset = 12'd32;

  typedef enum logic {
    OP_ALLOC,
    OP_FREE
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE,
    STATUS_FULL,
    STATUS_IGNORED
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CPU_BASE,
    CFG_GPU_BASE,
    CFG_SLOT_STRIDE
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_DATA,
    ST_ADD,
    ST_DIV,
    ST_FREE_CHK,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic pop;
    logic push;
    logic bm_rd;
    logic bm_wr;
    logic bm_set;
  } store_cmd_t;

endpackage

>>> rtl/dsa_serial_add.sv
// Bit-serial 64-bit adder that adds one bit per cycle through shift registers.
module dsa_serial_add (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dsa_pkg::AddrW-1:0] a_i,
  input  logic [dsa_pkg::AddrW-1:0] b_i,
  output logic                      busy_o,
  output logic [dsa_pkg::AddrW-1:0] sum_o
);
  import dsa_pkg::*;

  localparam int unsigned CntW = $clog2(AddrW);

  logic [AddrW-1:0] a_q, a_d;
  logic [AddrW-1:0] b_q, b_d;
  logic             carry_q, carry_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             sum_bit;

  assign sum_bit = a_q[0] ^ b_q[0] ^ carry_q;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    carry_d = carry_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d = a_i;
      b_d = b_i;
      carry_d = 1'b0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d = {sum_bit, a_q[AddrW-1:1]};
      b_d = {1'b0, b_q[AddrW-1:1]};
      carry_d = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(AddrW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      carry_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign busy_o = busy_q;
  assign sum_o = a_q;

endmodule

>>> rtl/dsa_serial_div.sv
// Restoring divider that produces one quotient bit per cycle for a 64-bit dividend.
module dsa_serial_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dsa_pkg::AddrW-1:0]   dividend_i,
  input  logic [dsa_pkg::StrideW-1:0] divisor_i,
  output logic                        busy_o,
  output logic [dsa_pkg::AddrW-1:0]   quotient_o
);
  import dsa_pkg::*;

  localparam int unsigned CntW = $clog2(AddrW);

  logic [AddrW-1:0]   dq_q, dq_d;
  logic [StrideW-1:0] rem_q, rem_d;
  logic [StrideW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [StrideW:0]   trial;
  logic [StrideW:0]   diff;
  logic               ge;

  assign trial = {rem_q, dq_q[AddrW-1]};
  assign ge = trial >= {1'b0, dvs_q};
  assign diff = trial - {1'b0, dvs_q};

  always_comb begin
    dq_d = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dq_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[StrideW-1:0] : trial[StrideW-1:0];
      dq_d = {dq_q[AddrW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(AddrW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quotient_o = dq_q;

endmodule

>>> rtl/dsa_slot_store.sv
// Free queue memory, used bitmap memory, queue pointers and the bitmap clearing pass.
module dsa_slot_store #(
  parameter int unsigned SLOT_COUNT = dsa_pkg::SlotCountDefault,
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsa_pkg::store_cmd_t cmd_i,
  input  logic [IdxW-1:0]     idx_i,
  output logic                clearing_o,
  output logic [IdxW-1:0]     pop_idx_o,
  output logic                used_o,
  output logic [CntW-1:0]     free_count_o
);
  import dsa_pkg::*;

  logic [IdxW-1:0] queue_mem [SLOT_COUNT];
  logic            bm_mem [SLOT_COUNT];

  logic [IdxW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q;
  logic            wrapped_q;
  logic            clearing_q;
  logic [IdxW-1:0] clr_q;
  logic [IdxW-1:0] rd_data_q;
  logic [IdxW-1:0] rd_pos_q;
  logic            rd_fresh_q;
  logic            bm_data_q;
  logic            fresh;
  logic            bm_we;
  logic [IdxW-1:0] bm_addr;
  logic            bm_val;

  // A queue position that was never written is read as its own index instead of the memory contents.
  assign fresh = !wrapped_q && (head_q >= tail_q);

  assign bm_we = clearing_q || cmd_i.bm_wr;
  assign bm_addr = clearing_q ? clr_q : idx_i;
  assign bm_val = clearing_q ? 1'b0 : cmd_i.bm_set;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      rd_data_q <= queue_mem[head_q];
      rd_pos_q <= head_q;
      rd_fresh_q <= fresh;
    end
    if (cmd_i.push) begin
      queue_mem[tail_q] <= idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bm_rd) begin
      bm_data_q <= bm_mem[idx_i];
    end
    if (bm_we) begin
      bm_mem[bm_addr] <= bm_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      count_q <= CntW'(SLOT_COUNT);
      wrapped_q <= 1'b0;
      clearing_q <= 1'b1;
      clr_q <= '0;
    end else begin
      if (clearing_q) begin
        if (clr_q == IdxW'(SLOT_COUNT - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_q <= clr_q + 1'b1;
        end
      end
      if (cmd_i.pop) begin
        head_q <= (head_q == IdxW'(SLOT_COUNT - 1)) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.push) begin
        if (tail_q == IdxW'(SLOT_COUNT - 1)) begin
          tail_q <= '0;
          wrapped_q <= 1'b1;
        end else begin
          tail_q <= tail_q + 1'b1;
        end
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign clearing_o = clearing_q;
  assign pop_idx_o = rd_fresh_q ? rd_pos_q : rd_data_q;
  assign used_o = bm_data_q;
  assign free_count_o = count_q;

endmodule

>>> rtl/descriptor_slot_allocator.sv
// Descriptor slot allocator: top level with control sequencer, configuration and result register.
// After reset the used bitmap is swept clear in a clearing pass, during which no item is
// taken; configuration writes are taken at any time. An allocate runs its two address sums
// through two 64-bit bit-serial adders, and the item moves on to the output stage once both are done.
// A free by address divides by the stride in a bit-serial divider, one quotient bit per
// cycle, then checks the used bit of the slot it names. A free by index checks that bit
// directly, and an allocate on a full table or a free that is rejected at once goes
// straight to the output stage. One item is in work at a time; the next is taken in the
// cycle after the result is loaded, while that result may still wait in the output register.
module descriptor_slot_allocator #(
  parameter int unsigned SLOT_COUNT = dsa_pkg::SlotCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic                          by_address_i,
  input  logic [dsa_pkg::IndexW-1:0]    free_index_i,
  input  logic [dsa_pkg::AddrW-1:0]     free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [dsa_pkg::IndexW-1:0]    slot_index_o,
  output logic [dsa_pkg::AddrW-1:0]     cpu_address_o,
  output logic [dsa_pkg::AddrW-1:0]     gpu_address_o,
  output logic [dsa_pkg::UsedW-1:0]     used_count_o,
  input  logic                          cfg_we_i,
  input  logic [dsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsa_pkg::AddrW-1:0]     cfg_data_i
);
  import dsa_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned OffW = IdxW + StrideW;

  logic [AddrW-1:0]   cpu_base_q, gpu_base_q;
  logic [StrideW-1:0] stride_q;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  status_e         status_q, status_d;
  logic [IdxW-1:0] cand_q, cand_d;

  store_cmd_t      cmd;
  logic [IdxW-1:0] store_idx;
  logic            clearing;
  logic [IdxW-1:0] pop_idx;
  logic            used_bit;
  logic [CntW-1:0] free_count;

  logic             div_start, div_busy;
  logic [AddrW-1:0] quotient;
  logic             add_start, cpu_busy, gpu_busy, add_busy;
  logic [AddrW-1:0] cpu_sum, gpu_sum;
  logic [OffW-1:0]  offset;
  logic             idx_ok;
  logic             out_load;
  logic [31:0]      used_w;

  status_e            out_status_q;
  logic               out_valid_q, out_valid_d;
  logic [IndexW-1:0]  out_idx_q;
  logic [AddrW-1:0]   out_cpu_q, out_gpu_q;
  logic [UsedW-1:0]   out_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      stride_q <= StrideReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CPU_BASE:    cpu_base_q <= cfg_data_i;
        CFG_GPU_BASE:    gpu_base_q <= cfg_data_i;
        CFG_SLOT_STRIDE: stride_q <= cfg_data_i[StrideW-1:0];
        default: ;
      endcase
    end
  end

  dsa_slot_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .idx_i(store_idx),
    .clearing_o(clearing),
    .pop_idx_o(pop_idx),
    .used_o(used_bit),
    .free_count_o(free_count)
  );

  dsa_serial_div u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .dividend_i(free_address_i - cpu_base_q),
    .divisor_i(stride_q),
    .busy_o(div_busy),
    .quotient_o(quotient)
  );

  assign offset = OffW'(pop_idx) * OffW'(stride_q);

  dsa_serial_add u_cpu_add (
    .clk_i,
    .rst_ni,
    .start_i(add_start),
    .a_i(cpu_base_q),
    .b_i(AddrW'(offset)),
    .busy_o(cpu_busy),
    .sum_o(cpu_sum)
  );

  dsa_serial_add u_gpu_add (
    .clk_i,
    .rst_ni,
    .start_i(add_start),
    .a_i(gpu_base_q),
    .b_i(AddrW'(offset)),
    .busy_o(gpu_busy),
    .sum_o(gpu_sum)
  );

  assign add_busy = cpu_busy | gpu_busy;
  assign idx_ok = 32'(free_index_i) < 32'(SLOT_COUNT);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    status_d = status_q;
    cand_d = cand_q;
    cmd = '0;
    store_idx = cand_q;
    div_start = 1'b0;
    add_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (!clearing) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = op_e'(op_i);
          if (op_i == OP_ALLOC) begin
            if (free_count == '0) begin
              status_d = STATUS_FULL;
              state_d = ST_HOLD;
            end else begin
              cmd.pop = 1'b1;
              state_d = ST_ALLOC_DATA;
            end
          end else if (by_address_i) begin
            if (stride_q == '0) begin
              status_d = STATUS_IGNORED;
              state_d = ST_HOLD;
            end else begin
              div_start = 1'b1;
              state_d = ST_DIV;
            end
          end else if (idx_ok) begin
            cand_d = free_index_i[IdxW-1:0];
            store_idx = free_index_i[IdxW-1:0];
            cmd.bm_rd = 1'b1;
            state_d = ST_FREE_CHK;
          end else begin
            status_d = STATUS_IGNORED;
            state_d = ST_HOLD;
          end
        end
      end
      ST_ALLOC_DATA: begin
        cand_d = pop_idx;
        store_idx = pop_idx;
        cmd.bm_wr = 1'b1;
        cmd.bm_set = 1'b1;
        add_start = 1'b1;
        status_d = STATUS_DONE;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!add_busy) begin
          state_d = ST_HOLD;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          if (quotient < AddrW'(SLOT_COUNT)) begin
            cand_d = quotient[IdxW-1:0];
            store_idx = quotient[IdxW-1:0];
            cmd.bm_rd = 1'b1;
            state_d = ST_FREE_CHK;
          end else begin
            status_d = STATUS_IGNORED;
            state_d = ST_HOLD;
          end
        end
      end
      ST_FREE_CHK: begin
        if (used_bit && (32'(free_count) < 32'(SLOT_COUNT))) begin
          cmd.push = 1'b1;
          cmd.bm_wr = 1'b1;
          status_d = STATUS_DONE;
        end else begin
          status_d = STATUS_IGNORED;
        end
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q <= OP_ALLOC;
      status_q <= STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      status_q <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign used_w = 32'(SLOT_COUNT) - 32'(free_count);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_idx_q <= (status_q == STATUS_DONE) ? IndexW'(cand_q) : '0;
      out_cpu_q <= (status_q == STATUS_DONE && op_q == OP_ALLOC) ? cpu_sum : '0;
      out_gpu_q <= (status_q == STATUS_DONE && op_q == OP_ALLOC) ? gpu_sum : '0;
      out_used_q <= used_w[UsedW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign slot_index_o = out_idx_q;
  assign cpu_address_o = out_cpu_q;
  assign gpu_address_o = out_gpu_q;
  assign used_count_o = out_used_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_count) <= 32'(SLOT_COUNT))
    else $error("Free count exceeds the slot count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_DONE) |->
      (slot_index_o == '0) && (cpu_address_o == '0) && (gpu_address_o == '0))
    else $error("A failed or ignored result carries a slot or an address.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_ALLOC) && (free_count != '0) |=>
      free_count == $past(free_count) - 1'b1)
    else $error("An allocate transfer did not take one slot from the free queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy && add_busy))
    else $error("Divider and address adders are busy at the same time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("An item was offered acceptance during the bitmap clearing pass.");

endmodule
